// ----- sv/char_lcd_nibble_sequencer_defines.svh -----
// Assertion macros shared by the RTL.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// Property holds at every clock edge out of reset.
`define CLN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition never occurs out of reset.
`define CLN_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CLN_ASSERT(label, prop, msg)
`define CLN_NEVER(label, expr, msg)
`endif

`endif

// ----- sv/cln_pkg.sv -----
package cln_pkg;

  typedef enum logic [2:0] {
    OP_CHAR   = 3'd0,
    OP_CMD    = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_HOME   = 3'd3,
    OP_CURSOR = 3'd4,
    OP_INIT   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_SETUP  = 2'd0,
    ST_NIB    = 2'd1,
    ST_RS_LOW = 2'd2,
    ST_TRAIL  = 2'd3
  } state_t;

  localparam logic [7:0] CMD_FUNC_SET = 8'h28;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_HOME     = 8'h02;
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [3:0] NIB_FUNC_SET = 4'h2;

  localparam logic [6:0] ROW_OFS_0 = 7'h00;
  localparam logic [6:0] ROW_OFS_1 = 7'h40;
  localparam logic [6:0] ROW_OFS_2 = 7'h14;
  localparam logic [6:0] ROW_OFS_3 = 7'h54;

  localparam logic [1:0] CFG_ROW_OFS_0 = 2'd0;
  localparam logic [1:0] CFG_ROW_OFS_1 = 2'd1;
  localparam logic [1:0] CFG_ROW_OFS_2 = 2'd2;
  localparam logic [1:0] CFG_ROW_OFS_3 = 2'd3;

  localparam logic [10:0] HOLD_SETUP   = 11'd10;
  localparam logic [10:0] HOLD_DATA    = 11'd20;
  localparam logic [10:0] HOLD_EN      = 11'd10;
  localparam logic [10:0] HOLD_RS_LOW  = 11'd10;
  localparam logic [10:0] TRAIL_CHAR   = 11'd50;
  localparam logic [10:0] TRAIL_CMD    = 11'd0;
  localparam logic [10:0] TRAIL_CLEAR  = 11'd2000;
  localparam logic [10:0] TRAIL_CURSOR = 11'd40;

  localparam logic [1:0] INIT_LAST_BYTE = 2'd3;
  localparam logic [1:0] PH_EN_LOW      = 2'd2;

  // Accepted operation
  typedef struct packed {
    op_t        op;
    logic [7:0] byte_value;
    logic [6:0] addr;
  } item_t;

  // Position inside the event sequence of one operation
  typedef struct packed {
    state_t     state;
    logic [1:0] grp;
    logic [1:0] phase;
    logic [1:0] byte_idx;
  } pos_t;

  typedef struct packed {
    logic        reg_select;
    logic        read_write;
    logic        enable;
    logic [3:0]  data_nibble;
    logic [10:0] hold_us;
    logic        last;
  } evt_t;

  // Sequencing status from the event decoder
  typedef struct packed {
    logic lo_grp;
    logic final_byte;
  } gen_stat_t;

endpackage

// ----- sv/cln_if.sv -----
interface cln_op_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] byte_value;
  logic [6:0] column;
  logic [1:0] row;

  modport source (output valid, op, byte_value, column, row, input ready);
  modport sink (input valid, op, byte_value, column, row, output ready);
endinterface

interface cln_evt_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic        read_write;
  logic        enable;
  logic [3:0]  data_nibble;
  logic [10:0] hold_us;
  logic        last;

  modport source (output valid, reg_select, read_write, enable, data_nibble, hold_us, last,
                  input ready);
  modport sink (input valid, reg_select, read_write, enable, data_nibble, hold_us, last,
                output ready);
endinterface

// ----- sv/cln_event_gen.sv -----
// Decodes the pin event for the current item and sequence position.
module cln_event_gen (
  input  cln_pkg::item_t     item,
  input  cln_pkg::pos_t      pos,
  output cln_pkg::evt_t      evt,
  output cln_pkg::gen_stat_t stat
);

  logic [7:0]  cur_byte;
  logic [10:0] trail;
  logic        rs;
  logic        rep;
  logic [3:0]  hi;
  logic [3:0]  lo;

  always_comb begin
    cur_byte = cln_pkg::CMD_CLEAR;
    trail    = cln_pkg::TRAIL_CMD;
    case (item.op)
      cln_pkg::OP_CHAR: begin
        cur_byte = item.byte_value;
        trail    = cln_pkg::TRAIL_CHAR;
      end
      cln_pkg::OP_CMD: begin
        cur_byte = item.byte_value;
        trail    = cln_pkg::TRAIL_CMD;
      end
      cln_pkg::OP_CLEAR: begin
        cur_byte = cln_pkg::CMD_CLEAR;
        trail    = cln_pkg::TRAIL_CLEAR;
      end
      cln_pkg::OP_HOME: begin
        cur_byte = cln_pkg::CMD_HOME;
        trail    = cln_pkg::TRAIL_CLEAR;
      end
      cln_pkg::OP_CURSOR: begin
        cur_byte = cln_pkg::CMD_SET_ADDR | {1'b0, item.addr};
        trail    = cln_pkg::TRAIL_CURSOR;
      end
      cln_pkg::OP_INIT: begin
        case (pos.byte_idx)
          2'd0:    cur_byte = cln_pkg::CMD_FUNC_SET;
          2'd1:    cur_byte = cln_pkg::CMD_DISP_ON;
          2'd2:    cur_byte = cln_pkg::CMD_ENTRY;
          default: cur_byte = cln_pkg::CMD_CLEAR;
        endcase
        trail = (pos.byte_idx == cln_pkg::INIT_LAST_BYTE) ? cln_pkg::TRAIL_CLEAR
                                                          : cln_pkg::TRAIL_CMD;
      end
      default: begin
        cur_byte = cln_pkg::CMD_CLEAR;
        trail    = cln_pkg::TRAIL_CMD;
      end
    endcase
  end

  assign rs  = (item.op == cln_pkg::OP_CHAR);
  assign hi  = cur_byte[7:4];
  assign lo  = cur_byte[3:0];
  // function set sends its high nibble twice
  assign rep = !rs && (hi == cln_pkg::NIB_FUNC_SET);

  assign stat.lo_grp     = (pos.grp == (rep ? 2'd2 : 2'd1));
  assign stat.final_byte = (item.op != cln_pkg::OP_INIT) ||
                           (pos.byte_idx == cln_pkg::INIT_LAST_BYTE);

  always_comb begin
    evt            = '0;
    evt.read_write = 1'b0;
    case (pos.state)
      cln_pkg::ST_SETUP: begin
        evt.reg_select = rs;
        evt.hold_us    = cln_pkg::HOLD_SETUP;
      end
      cln_pkg::ST_NIB: begin
        evt.reg_select  = rs;
        evt.data_nibble = stat.lo_grp ? lo : hi;
        evt.enable      = (pos.phase == 2'd1);
        evt.hold_us     = (pos.phase == 2'd1) ? cln_pkg::HOLD_EN : cln_pkg::HOLD_DATA;
      end
      cln_pkg::ST_RS_LOW: begin
        evt.data_nibble = lo;
        evt.hold_us     = cln_pkg::HOLD_RS_LOW;
      end
      cln_pkg::ST_TRAIL: begin
        evt.hold_us = trail;
        evt.last    = stat.final_byte;
      end
      default: begin
        evt = '0;
      end
    endcase
  end

endmodule

// ----- sv/char_lcd_nibble_sequencer.sv -----
// Channel  Dir  Contents
// in_if    in   op, byte_value, column, row
// out_if   out  reg_select, read_write, enable, data_nibble, hold_us, last
// cfg_*    in   row offset writes, index 0..3
//
// One operation gives 9 words (12 for a function-set command, 39 for init),
// one word per cycle from the sequence counters into the output register.
// The next operation is taken in the cycle its predecessor's last word loads.
// Ops 6 and 7 are taken and dropped; they give no word.
// Reset (synchronous, rst_n low) empties the block and loads default row offsets.
// A stalled output holds its word and freezes the sequence.
`include "char_lcd_nibble_sequencer_defines.svh"

module char_lcd_nibble_sequencer (
  input  logic             clk,
  input  logic             rst_n,
  cln_op_if.sink           in_if,
  cln_evt_if.source        out_if,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [6:0]       cfg_wdata
);

  logic [6:0]         row_ofs_r [4];
  logic               item_valid_r;
  cln_pkg::item_t     item_r;
  cln_pkg::state_t    state_r;
  cln_pkg::state_t    state_nxt;
  logic [1:0]         grp_r;
  logic [1:0]         grp_nxt;
  logic [1:0]         phase_r;
  logic [1:0]         phase_nxt;
  logic [1:0]         byte_idx_r;
  logic [1:0]         byte_idx_nxt;
  logic               out_valid_r;
  cln_pkg::evt_t      out_evt_r;

  cln_pkg::pos_t      pos;
  cln_pkg::evt_t      evt;
  cln_pkg::gen_stat_t stat;
  cln_pkg::item_t     new_item;
  logic               accept;
  logic               op_ok;
  logic               adv;
  logic               done;

  assign accept = in_if.valid && in_if.ready;
  assign op_ok  = (in_if.op <= cln_pkg::OP_INIT);
  assign adv    = item_valid_r && (!out_valid_r || out_if.ready);
  assign done   = adv && evt.last;

  assign in_if.ready = !item_valid_r || done;

  assign new_item.op         = cln_pkg::op_t'(in_if.op);
  assign new_item.byte_value = in_if.byte_value;
  assign new_item.addr       = in_if.column + row_ofs_r[in_if.row];

  assign pos.state    = state_r;
  assign pos.grp      = grp_r;
  assign pos.phase    = phase_r;
  assign pos.byte_idx = byte_idx_r;

  cln_event_gen u_event_gen (
    .item (item_r),
    .pos  (pos),
    .evt  (evt),
    .stat (stat)
  );

  // next position in the sequence
  always_comb begin
    state_nxt    = state_r;
    grp_nxt      = grp_r;
    phase_nxt    = phase_r;
    byte_idx_nxt = byte_idx_r;
    case (state_r)
      cln_pkg::ST_SETUP: begin
        state_nxt = cln_pkg::ST_NIB;
        grp_nxt   = 2'd0;
        phase_nxt = 2'd0;
      end
      cln_pkg::ST_NIB: begin
        if (phase_r == cln_pkg::PH_EN_LOW) begin
          phase_nxt = 2'd0;
          if (stat.lo_grp) begin
            state_nxt = cln_pkg::ST_RS_LOW;
          end else begin
            grp_nxt = grp_r + 2'd1;
          end
        end else begin
          phase_nxt = phase_r + 2'd1;
        end
      end
      cln_pkg::ST_RS_LOW: begin
        state_nxt = cln_pkg::ST_TRAIL;
      end
      cln_pkg::ST_TRAIL: begin
        state_nxt    = cln_pkg::ST_SETUP;
        grp_nxt      = 2'd0;
        byte_idx_nxt = byte_idx_r + 2'd1;
      end
      default: begin
        state_nxt = cln_pkg::ST_SETUP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      state_r      <= cln_pkg::ST_SETUP;
      grp_r        <= 2'd0;
      phase_r      <= 2'd0;
      byte_idx_r   <= 2'd0;
      row_ofs_r[0] <= cln_pkg::ROW_OFS_0;
      row_ofs_r[1] <= cln_pkg::ROW_OFS_1;
      row_ofs_r[2] <= cln_pkg::ROW_OFS_2;
      row_ofs_r[3] <= cln_pkg::ROW_OFS_3;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cln_pkg::CFG_ROW_OFS_0: row_ofs_r[0] <= cfg_wdata;
          cln_pkg::CFG_ROW_OFS_1: row_ofs_r[1] <= cfg_wdata;
          cln_pkg::CFG_ROW_OFS_2: row_ofs_r[2] <= cfg_wdata;
          cln_pkg::CFG_ROW_OFS_3: row_ofs_r[3] <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        item_valid_r <= op_ok;
        state_r      <= cln_pkg::ST_SETUP;
        grp_r        <= 2'd0;
        phase_r      <= 2'd0;
        byte_idx_r   <= 2'd0;
      end else if (adv) begin
        item_valid_r <= !done;
        state_r      <= state_nxt;
        grp_r        <= grp_nxt;
        phase_r      <= phase_nxt;
        byte_idx_r   <= byte_idx_nxt;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= new_item;
    end
    if (adv) begin
      out_evt_r <= evt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.reg_select  = out_evt_r.reg_select;
  assign out_if.read_write  = out_evt_r.read_write;
  assign out_if.enable      = out_evt_r.enable;
  assign out_if.data_nibble = out_evt_r.data_nibble;
  assign out_if.hold_us     = out_evt_r.hold_us;
  assign out_if.last        = out_evt_r.last;

  `CLN_ASSERT(a_last_from_trail, adv && evt.last |-> state_r == cln_pkg::ST_TRAIL, "last word outside trail step")
  `CLN_ASSERT(a_accept_starts, accept && op_ok |=> item_valid_r && state_r == cln_pkg::ST_SETUP, "accepted op did not start")
  `CLN_NEVER(a_phase_range, state_r == cln_pkg::ST_NIB && phase_r == 2'd3, "nibble phase out of range")
  `CLN_ASSERT(a_multi_byte_init, item_valid_r && byte_idx_r != 2'd0 |-> item_r.op == cln_pkg::OP_INIT, "byte index moved on single-byte op")
  `CLN_ASSERT(a_word_loaded, adv |=> out_valid_r, "advanced without loading output word")

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;

  // Pin timing in microseconds
  localparam logic [10:0] T_SETUP     = 11'd10;
  localparam logic [10:0] T_DATA      = 11'd20;
  localparam logic [10:0] T_STROBE    = 11'd10;
  localparam logic [10:0] T_RS_DROP   = 11'd10;
  localparam logic [10:0] TAIL_CHAR   = 11'd50;
  localparam logic [10:0] TAIL_CMD    = 11'd0;
  localparam logic [10:0] TAIL_SLOW   = 11'd2000;
  localparam logic [10:0] TAIL_CURSOR = 11'd40;

  localparam logic [7:0] LCD_FUNC_SET = 8'h28;
  localparam logic [7:0] LCD_DISP_ON  = 8'h0C;
  localparam logic [7:0] LCD_ENTRY    = 8'h06;
  localparam logic [7:0] LCD_CLEAR    = 8'h01;
  localparam logic [7:0] LCD_HOME     = 8'h02;

  // op codes with no meaning; the block swallows them
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam int SETTLE_CYCLES = 50;
  localparam int CHOKE_CYCLES  = 400;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] byte_value;
    logic [6:0] column;
    logic [1:0] row;
  } lcd_op_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [6:0] cfg_wdata;

  cln_op_if  op_ch();
  cln_evt_if evt_ch();

  char_lcd_nibble_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (op_ch),
    .out_if    (evt_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lcd_op_t       ops_pending[$];
  lcd_op_t       op_on_bus;
  cln_pkg::evt_t pins_expected[$];
  logic [6:0]    row_ofs [4];
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            choke_reqs = 0;
  int            choke_taken;
  int            choke_left;
  int            errors = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------- pin event prediction ----------------

  function automatic void push_pins(logic rs, logic en, logic [3:0] nib, logic [10:0] hold);
    cln_pkg::evt_t e;
    e.reg_select  = rs;
    e.read_write  = 1'b0;
    e.enable      = en;
    e.data_nibble = nib;
    e.hold_us     = hold;
    e.last        = 1'b0;
    pins_expected.push_back(e);
  endfunction

  function automatic void push_nibble(logic rs, logic [3:0] nib);
    push_pins(rs, 1'b0, nib, T_DATA);
    push_pins(rs, 1'b1, nib, T_STROBE);
    push_pins(rs, 1'b0, nib, T_DATA);
  endfunction

  function automatic void push_byte(logic rs, logic [7:0] value, logic [10:0] tail);
    push_pins(rs, 1'b0, 4'h0, T_SETUP);
    // function set repeats its high nibble; character data never does
    if (!rs && value[7:4] == LCD_FUNC_SET[7:4])
      push_nibble(rs, value[7:4]);
    push_nibble(rs, value[7:4]);
    push_nibble(rs, value[3:0]);
    push_pins(1'b0, 1'b0, value[3:0], T_RS_DROP);
    push_pins(1'b0, 1'b0, 4'h0, tail);
  endfunction

  function automatic void predict_pins(lcd_op_t o);
    int start_sz;
    start_sz = pins_expected.size();
    case (o.op)
      cln_pkg::OP_CHAR:   push_byte(1'b1, o.byte_value, TAIL_CHAR);
      cln_pkg::OP_CMD:    push_byte(1'b0, o.byte_value, TAIL_CMD);
      cln_pkg::OP_CLEAR:  push_byte(1'b0, LCD_CLEAR, TAIL_SLOW);
      cln_pkg::OP_HOME:   push_byte(1'b0, LCD_HOME, TAIL_SLOW);
      cln_pkg::OP_CURSOR: push_byte(1'b0, {1'b1, o.column + row_ofs[o.row]}, TAIL_CURSOR);
      cln_pkg::OP_INIT: begin
        push_byte(1'b0, LCD_FUNC_SET, TAIL_CMD);
        push_byte(1'b0, LCD_DISP_ON, TAIL_CMD);
        push_byte(1'b0, LCD_ENTRY, TAIL_CMD);
        push_byte(1'b0, LCD_CLEAR, TAIL_SLOW);
      end
      default: ;
    endcase
    if (pins_expected.size() > start_sz)
      pins_expected[pins_expected.size() - 1].last = 1'b1;
  endfunction

  // ---------------- checking ----------------

  function automatic void cmp_field(string name, logic [10:0] want, logic [10:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_pins();
    cln_pkg::evt_t want;
    if (pins_expected.size() == 0) begin
      $error("unexpected word: nibble %0h hold %0d", evt_ch.data_nibble, evt_ch.hold_us);
      errors++;
      return;
    end
    want = pins_expected.pop_front();
    cmp_field("reg_select", 11'(want.reg_select), 11'(evt_ch.reg_select));
    cmp_field("read_write", 11'(want.read_write), 11'(evt_ch.read_write));
    cmp_field("enable", 11'(want.enable), 11'(evt_ch.enable));
    cmp_field("data_nibble", 11'(want.data_nibble), 11'(evt_ch.data_nibble));
    cmp_field("hold_us", want.hold_us, evt_ch.hold_us);
    cmp_field("last", 11'(want.last), 11'(evt_ch.last));
  endfunction

  // ---------------- op driver ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      op_ch.valid <= 1'b0;
    end else begin
      if (op_ch.valid && op_ch.ready)
        predict_pins(op_on_bus);
      if (!op_ch.valid || op_ch.ready) begin
        if (ops_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          op_on_bus = ops_pending.pop_front();
          op_ch.valid      <= 1'b1;
          op_ch.op         <= op_on_bus.op;
          op_ch.byte_value <= op_on_bus.byte_value;
          op_ch.column     <= op_on_bus.column;
          op_ch.row        <= op_on_bus.row;
        end else begin
          op_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- pin monitor ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      evt_ch.ready <= 1'b0;
      choke_taken  <= 0;
      choke_left   <= 0;
    end else begin
      if (evt_ch.valid && evt_ch.ready)
        check_pins();
      if (choke_taken != choke_reqs) begin
        choke_taken  <= choke_reqs;
        choke_left   <= CHOKE_CYCLES;
        evt_ch.ready <= 1'b0;
      end else if (choke_left > 0) begin
        choke_left   <= choke_left - 1;
        evt_ch.ready <= 1'b0;
      end else begin
        evt_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------- stimulus ----------------

  function automatic void add_op(logic [2:0] op, logic [7:0] b, logic [6:0] col, logic [1:0] r);
    lcd_op_t o;
    o.op         = op;
    o.byte_value = b;
    o.column     = col;
    o.row        = r;
    ops_pending.push_back(o);
  endfunction

  function automatic void queue_directed();
    add_op(cln_pkg::OP_CHAR, 8'h00, 7'h00, 2'd0);
    add_op(cln_pkg::OP_CHAR, 8'hFF, 7'h7F, 2'd3);
    add_op(cln_pkg::OP_CHAR, 8'h20, 7'h00, 2'd0);   // space: no repeated nibble for data
    add_op(cln_pkg::OP_CHAR, 8'h2F, 7'h00, 2'd0);
    add_op(cln_pkg::OP_CMD, LCD_FUNC_SET, 7'h00, 2'd0);
    add_op(cln_pkg::OP_CMD, 8'h20, 7'h00, 2'd0);
    add_op(cln_pkg::OP_CMD, 8'h2F, 7'h7F, 2'd3);
    add_op(cln_pkg::OP_CMD, 8'h00, 7'h00, 2'd0);
    add_op(cln_pkg::OP_CMD, 8'hFF, 7'h00, 2'd0);
    add_op(cln_pkg::OP_CMD, LCD_DISP_ON, 7'h00, 2'd0);
    add_op(cln_pkg::OP_CLEAR, 8'hFF, 7'h7F, 2'd3);
    add_op(cln_pkg::OP_HOME, 8'h00, 7'h00, 2'd0);
    add_op(cln_pkg::OP_CURSOR, 8'h00, 7'h00, 2'd0);
    add_op(cln_pkg::OP_CURSOR, 8'hFF, 7'h7F, 2'd3);  // address wraps past 127
    add_op(cln_pkg::OP_CURSOR, 8'h00, 7'h7F, 2'd1);
    add_op(cln_pkg::OP_CURSOR, 8'h00, 7'h3F, 2'd2);
    add_op(cln_pkg::OP_CURSOR, 8'h00, 7'h05, 2'd0);
    add_op(cln_pkg::OP_INIT, 8'hFF, 7'h7F, 2'd3);
    add_op(OP_SPARE_LO, 8'h41, 7'h10, 2'd1);
    add_op(OP_SPARE_HI, 8'hFF, 7'h7F, 2'd3);
    add_op(cln_pkg::OP_CHAR, 8'h41, 7'h55, 2'd2);
    add_op(cln_pkg::OP_INIT, 8'h00, 7'h00, 2'd0);
  endfunction

  function automatic void queue_random(int count);
    lcd_op_t o;
    int made;
    int pick;
    made = 0;
    while (made < count) begin
      o.byte_value = 8'($urandom);
      o.column     = 7'($urandom);
      o.row        = 2'($urandom);
      pick = $urandom_range(99);
      if (pick < 33) begin
        o.op = cln_pkg::OP_CHAR;
        if ($urandom_range(3) == 0)
          o.byte_value[7:4] = LCD_FUNC_SET[7:4];
      end else if (pick < 55) begin
        o.op = cln_pkg::OP_CMD;
        if ($urandom_range(2) == 0)
          o.byte_value[7:4] = LCD_FUNC_SET[7:4];
      end else if (pick < 62) begin
        o.op = cln_pkg::OP_CLEAR;
      end else if (pick < 69) begin
        o.op = cln_pkg::OP_HOME;
      end else if (pick < 86) begin
        o.op = cln_pkg::OP_CURSOR;
      end else if (pick < 94) begin
        o.op = cln_pkg::OP_INIT;
      end else begin
        o.op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
      end
      if (o.op <= cln_pkg::OP_INIT)
        made++;
      ops_pending.push_back(o);
    end
  endfunction

  // Wait for every queued op to go in and every word to come out,
  // then let a swallowed op finish inside the block.
  task automatic settle();
    do
      @(posedge clk);
    while (ops_pending.size() != 0 || op_ch.valid || pins_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    @(posedge clk);
    cfg_we      <= 1'b1;
    cfg_index   <= idx;
    cfg_wdata   <= val;
    row_ofs[idx] = val;
  endtask

  task automatic load_offsets(logic [6:0] o0, logic [6:0] o1, logic [6:0] o2, logic [6:0] o3);
    write_reg(cln_pkg::CFG_ROW_OFS_0, o0);
    write_reg(cln_pkg::CFG_ROW_OFS_1, o1);
    write_reg(cln_pkg::CFG_ROW_OFS_2, o2);
    write_reg(cln_pkg::CFG_ROW_OFS_3, o3);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    op_ch.valid      = 1'b0;
    op_ch.op         = '0;
    op_ch.byte_value = '0;
    op_ch.column     = '0;
    op_ch.row        = '0;
    evt_ch.ready     = 1'b0;
    row_ofs          = '{7'h00, 7'h40, 7'h14, 7'h54};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset offsets first
    queue_directed();
    settle();

    load_offsets(7'h7F, 7'h00, 7'h7F, 7'h00);
    send_idle_pct = 23;
    recv_idle_pct = 69;
    queue_random(105);
    settle();

    load_offsets(7'h00, 7'h7F, 7'h00, 7'h7F);
    send_idle_pct = 69;
    recv_idle_pct = 23;
    queue_random(105);
    settle();

    load_offsets(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(60);
    choke_reqs++;   // display side stalls while ops keep coming
    settle();       // sender holds back until all words are out
    queue_random(60);
    settle();

    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/cln_pkg.sv
sv/cln_if.sv
sv/cln_event_gen.sv
sv/char_lcd_nibble_sequencer.sv
tb/sv/tb_top.sv
